>>> hw/rtl/obct_pkg.sv
package obct_pkg;

    localparam int OP_W = 3;
    localparam int SLOT_W = 6;
    localparam int DIM_W = 15;
    localparam int STAT_W = 2;
    localparam int APB_DW = 32;
    localparam int APB_AW = 5;
    localparam int REG_IDX_W = APB_AW - 2;

    localparam logic [OP_W-1:0] OP_ADD = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [OP_W-1:0] OP_MOVE = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd3;
    localparam logic [OP_W-1:0] OP_BOX_QUERY = 3'd4;
    localparam logic [OP_W-1:0] OP_POINT_QUERY = 3'd5;

    localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BAD_INDEX = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_PLAYER_WIDTH = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PLAYER_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BOUND_LEFT = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BOUND_TOP = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_BOUND_WIDTH = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_BOUND_HEIGHT = 3'd5;

endpackage

>>> hw/rtl/obct_ram.sv
module obct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/obct_hit_unit.sv
module obct_hit_unit #(
    parameter int COORD_BITS = 16,
    parameter int SUM_W = 17
) (
    input  logic                     is_box,
    input  logic signed [SUM_W-1:0]  qx1,
    input  logic signed [SUM_W-1:0]  qx2,
    input  logic signed [SUM_W-1:0]  qy1,
    input  logic signed [SUM_W-1:0]  qy2,
    input  logic [COORD_BITS-1:0]    ox,
    input  logic [COORD_BITS-1:0]    oy,
    input  logic [obct_pkg::DIM_W-1:0] ow,
    input  logic [obct_pkg::DIM_W-1:0] oh,
    output logic                     hit
);
    import obct_pkg::*;

    logic signed [SUM_W-1:0] ox1;
    logic signed [SUM_W-1:0] ox2;
    logic signed [SUM_W-1:0] oy1;
    logic signed [SUM_W-1:0] oy2;
    logic px1_in;
    logic px2_in;
    logic py1_in;
    logic py2_in;
    logic ox1_in;
    logic ox2_in;
    logic oy1_in;
    logic oy2_in;
    logic p_in_o;
    logic o_in_p;

    assign ox1 = {{(SUM_W-COORD_BITS){ox[COORD_BITS-1]}}, ox};
    assign oy1 = {{(SUM_W-COORD_BITS){oy[COORD_BITS-1]}}, oy};
    assign ox2 = ox1 + $signed({{(SUM_W-DIM_W){1'b0}}, ow});
    assign oy2 = oy1 + $signed({{(SUM_W-DIM_W){1'b0}}, oh});

    assign px1_in = (qx1 >= ox1) && (qx1 <= ox2);
    assign px2_in = (qx2 >= ox1) && (qx2 <= ox2);
    assign py1_in = (qy1 >= oy1) && (qy1 <= oy2);
    assign py2_in = (qy2 >= oy1) && (qy2 <= oy2);
    assign ox1_in = (ox1 >= qx1) && (ox1 <= qx2);
    assign ox2_in = (ox2 >= qx1) && (ox2 <= qx2);
    assign oy1_in = (oy1 >= qy1) && (oy1 <= qy2);
    assign oy2_in = (oy2 >= qy1) && (oy2 <= qy2);

    assign p_in_o = (px1_in || px2_in) && (py1_in || py2_in);
    assign o_in_p = (ox1_in || ox2_in) && (oy1_in || oy2_in);

    assign hit = is_box ? (p_in_o || o_in_p) : (px1_in && py1_in);

endmodule

>>> hw/rtl/obstacle_box_collision_table_unit.sv
// Items are handled one at a time. An add, move, clear, unused or rejected transfer goes
// straight to the emit state, a remove first shifts each entry above the slot down one
// slot, and a query first walks every entry; out_valid is then registered from S_EMIT.
// The table RAMs are read one entry per cycle through a single shared hit unit.
// in_ready returns in the same cycle that out_valid rises; the last state holds while a
// result waits.
// rst_n is asynchronous and active low; it empties the table and clears the
// configuration and control registers.
module obstacle_box_collision_table_unit #(
    parameter int MAX_OBSTACLES = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [obct_pkg::APB_AW-1:0]         paddr,
    input  logic [obct_pkg::APB_DW-1:0]         pwdata,
    output logic [obct_pkg::APB_DW-1:0]         prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [obct_pkg::OP_W-1:0]           opcode,
    input  logic [obct_pkg::SLOT_W-1:0]         slot_index,
    input  logic [COORD_BITS-1:0]               pos_x,
    input  logic [COORD_BITS-1:0]               pos_y,
    input  logic [obct_pkg::DIM_W-1:0]          rect_width,
    input  logic [obct_pkg::DIM_W-1:0]          rect_height,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                hit,
    output logic                                out_of_bounds,
    output logic [$clog2(MAX_OBSTACLES+1)-1:0]  entry_count,
    output logic [obct_pkg::STAT_W-1:0]         status
);
    import obct_pkg::*;

    localparam int CNT_W = $clog2(MAX_OBSTACLES + 1);
    localparam int AW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
    localparam int SUM_W = ((COORD_BITS > DIM_W) ? COORD_BITS : DIM_W + 1) + 1;
    localparam int XW = ((CNT_W > SLOT_W) ? CNT_W : SLOT_W) + 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_REM  = 4'b0010,
        S_QRY  = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic pend_reg, pend_next;
    logic hit_reg, hit_next;
    logic is_box_reg, is_box_next;
    logic [STAT_W-1:0] op_status_reg, op_status_next;
    logic signed [SUM_W-1:0] qx_reg, qx_next;
    logic signed [SUM_W-1:0] qy_reg, qy_next;
    logic signed [SUM_W-1:0] qx2_reg, qx2_next;
    logic signed [SUM_W-1:0] qy2_reg, qy2_next;

    logic out_valid_reg, out_valid_next;
    logic out_hit_reg, out_hit_next;
    logic out_oob_reg, out_oob_next;
    logic [CNT_W-1:0] out_count_reg, out_count_next;
    logic [STAT_W-1:0] out_status_reg, out_status_next;

    logic [DIM_W-1:0] player_width_reg;
    logic [DIM_W-1:0] player_height_reg;
    logic [COORD_BITS-1:0] bound_left_reg;
    logic [COORD_BITS-1:0] bound_top_reg;
    logic [DIM_W-1:0] bound_width_reg;
    logic [DIM_W-1:0] bound_height_reg;

    logic [REG_IDX_W-1:0] reg_idx;
    logic cfg_write;

    logic pos_we;
    logic [AW-1:0] pos_waddr;
    logic [2*COORD_BITS-1:0] pos_wdata;
    logic [2*COORD_BITS-1:0] pos_rdata;
    logic dim_we;
    logic [AW-1:0] dim_waddr;
    logic [2*DIM_W-1:0] dim_wdata;
    logic [2*DIM_W-1:0] dim_rdata;
    logic [AW-1:0] rd_addr;

    logic entry_hit;
    logic accept;
    logic signed [SUM_W-1:0] in_x;
    logic signed [SUM_W-1:0] in_y;
    logic signed [SUM_W-1:0] bnd_x1;
    logic signed [SUM_W-1:0] bnd_y1;
    logic signed [SUM_W-1:0] bnd_x2;
    logic signed [SUM_W-1:0] bnd_y2;
    logic inside_bounds;
    logic [XW-1:0] slot_ext;
    logic [XW-1:0] count_ext;
    logic slot_ok;
    logic table_full;
    logic issue;
    logic [CNT_W-1:0] wr_idx;

    // Configuration registers.
    assign pready = 1'b1;
    assign reg_idx = paddr[APB_AW-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            player_width_reg <= '0;
            player_height_reg <= '0;
            bound_left_reg <= '0;
            bound_top_reg <= '0;
            bound_width_reg <= '0;
            bound_height_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_PLAYER_WIDTH:  player_width_reg <= pwdata[DIM_W-1:0];
                REG_PLAYER_HEIGHT: player_height_reg <= pwdata[DIM_W-1:0];
                REG_BOUND_LEFT:    bound_left_reg <= pwdata[COORD_BITS-1:0];
                REG_BOUND_TOP:     bound_top_reg <= pwdata[COORD_BITS-1:0];
                REG_BOUND_WIDTH:   bound_width_reg <= pwdata[DIM_W-1:0];
                REG_BOUND_HEIGHT:  bound_height_reg <= pwdata[DIM_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_PLAYER_WIDTH:  prdata = {{(APB_DW-DIM_W){1'b0}}, player_width_reg};
            REG_PLAYER_HEIGHT: prdata = {{(APB_DW-DIM_W){1'b0}}, player_height_reg};
            REG_BOUND_LEFT:    prdata = APB_DW'($signed(bound_left_reg));
            REG_BOUND_TOP:     prdata = APB_DW'($signed(bound_top_reg));
            REG_BOUND_WIDTH:   prdata = {{(APB_DW-DIM_W){1'b0}}, bound_width_reg};
            REG_BOUND_HEIGHT:  prdata = {{(APB_DW-DIM_W){1'b0}}, bound_height_reg};
            default:           prdata = '0;
        endcase
    end

    // Table storage.
    obct_ram #(
        .WIDTH (2 * COORD_BITS),
        .DEPTH (MAX_OBSTACLES),
        .AW    (AW)
    ) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (rd_addr),
        .rdata (pos_rdata)
    );

    obct_ram #(
        .WIDTH (2 * DIM_W),
        .DEPTH (MAX_OBSTACLES),
        .AW    (AW)
    ) u_dim_ram (
        .clk   (clk),
        .we    (dim_we),
        .waddr (dim_waddr),
        .wdata (dim_wdata),
        .raddr (rd_addr),
        .rdata (dim_rdata)
    );

    obct_hit_unit #(
        .COORD_BITS (COORD_BITS),
        .SUM_W      (SUM_W)
    ) u_hit_unit (
        .is_box (is_box_reg),
        .qx1    (qx_reg),
        .qx2    (qx2_reg),
        .qy1    (qy_reg),
        .qy2    (qy2_reg),
        .ox     (pos_rdata[2*COORD_BITS-1:COORD_BITS]),
        .oy     (pos_rdata[COORD_BITS-1:0]),
        .ow     (dim_rdata[2*DIM_W-1:DIM_W]),
        .oh     (dim_rdata[DIM_W-1:0]),
        .hit    (entry_hit)
    );

    // Sequencer.
    assign in_ready = (state_reg == S_IDLE);
    assign accept = in_valid && in_ready;

    assign in_x = {{(SUM_W-COORD_BITS){pos_x[COORD_BITS-1]}}, pos_x};
    assign in_y = {{(SUM_W-COORD_BITS){pos_y[COORD_BITS-1]}}, pos_y};
    assign slot_ext = {{(XW-SLOT_W){1'b0}}, slot_index};
    assign count_ext = {{(XW-CNT_W){1'b0}}, count_reg};
    assign slot_ok = (slot_ext < count_ext) && (slot_ext < XW'(MAX_OBSTACLES));
    assign table_full = (count_reg == CNT_W'(MAX_OBSTACLES));
    assign issue = (idx_reg < count_reg);
    assign rd_addr = idx_reg[AW-1:0];
    assign wr_idx = idx_reg - CNT_W'(2);

    assign bnd_x1 = {{(SUM_W-COORD_BITS){bound_left_reg[COORD_BITS-1]}}, bound_left_reg};
    assign bnd_y1 = {{(SUM_W-COORD_BITS){bound_top_reg[COORD_BITS-1]}}, bound_top_reg};
    assign bnd_x2 = bnd_x1 + $signed({{(SUM_W-DIM_W){1'b0}}, bound_width_reg});
    assign bnd_y2 = bnd_y1 + $signed({{(SUM_W-DIM_W){1'b0}}, bound_height_reg});
    assign inside_bounds = (qx_reg > bnd_x1) && (qx2_reg < bnd_x2) &&
                           (qy_reg > bnd_y1) && (qy2_reg < bnd_y2);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next = idx_reg;
        pend_next = pend_reg;
        hit_next = hit_reg;
        is_box_next = is_box_reg;
        op_status_next = op_status_reg;
        qx_next = qx_reg;
        qy_next = qy_reg;
        qx2_next = qx2_reg;
        qy2_next = qy2_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_hit_next = out_hit_reg;
        out_oob_next = out_oob_reg;
        out_count_next = out_count_reg;
        out_status_next = out_status_reg;
        pos_we = 1'b0;
        pos_waddr = count_reg[AW-1:0];
        pos_wdata = {pos_x, pos_y};
        dim_we = 1'b0;
        dim_waddr = count_reg[AW-1:0];
        dim_wdata = {rect_width, rect_height};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    hit_next = 1'b0;
                    is_box_next = 1'b0;
                    op_status_next = STAT_OK;
                    pend_next = 1'b0;
                    qx_next = in_x;
                    qy_next = in_y;
                    qx2_next = in_x + $signed({{(SUM_W-DIM_W){1'b0}}, player_width_reg});
                    qy2_next = in_y + $signed({{(SUM_W-DIM_W){1'b0}}, player_height_reg});
                    state_next = S_EMIT;
                    unique case (opcode)
                        OP_ADD:
                        begin
                            if (table_full)
                            begin
                                op_status_next = STAT_FULL;
                            end
                            else
                            begin
                                pos_we = 1'b1;
                                dim_we = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (slot_ok)
                            begin
                                idx_next = CNT_W'(slot_ext + XW'(1));
                                state_next = S_REM;
                            end
                            else
                            begin
                                op_status_next = STAT_BAD_INDEX;
                            end
                        end
                        OP_MOVE:
                        begin
                            if (slot_ok)
                            begin
                                pos_we = 1'b1;
                                pos_waddr = AW'(slot_index);
                            end
                            else
                            begin
                                op_status_next = STAT_BAD_INDEX;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        OP_BOX_QUERY:
                        begin
                            is_box_next = 1'b1;
                            idx_next = '0;
                            state_next = S_QRY;
                        end
                        OP_POINT_QUERY:
                        begin
                            idx_next = '0;
                            state_next = S_QRY;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_REM:
            begin
                // The entry read last cycle moves down into the slot below its own.
                pos_we = pend_reg;
                dim_we = pend_reg;
                pos_waddr = wr_idx[AW-1:0];
                dim_waddr = wr_idx[AW-1:0];
                pos_wdata = pos_rdata;
                dim_wdata = dim_rdata;
                pend_next = issue;
                if (issue)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                if (!issue && !pend_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_EMIT;
                end
            end
            S_QRY:
            begin
                pend_next = issue;
                if (issue)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                if (pend_reg && entry_hit)
                begin
                    hit_next = 1'b1;
                end
                if (!issue && !pend_reg)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next = hit_reg;
                    out_oob_next = is_box_reg && !inside_bounds;
                    out_count_next = count_reg;
                    out_status_next = op_status_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idx_reg <= '0;
            pend_reg <= 1'b0;
            hit_reg <= 1'b0;
            is_box_reg <= 1'b0;
            op_status_reg <= STAT_OK;
            out_valid_reg <= 1'b0;
            out_hit_reg <= 1'b0;
            out_oob_reg <= 1'b0;
            out_count_reg <= '0;
            out_status_reg <= STAT_OK;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg <= idx_next;
            pend_reg <= pend_next;
            hit_reg <= hit_next;
            is_box_reg <= is_box_next;
            op_status_reg <= op_status_next;
            out_valid_reg <= out_valid_next;
            out_hit_reg <= out_hit_next;
            out_oob_reg <= out_oob_next;
            out_count_reg <= out_count_next;
            out_status_reg <= out_status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qx_reg <= qx_next;
        qy_reg <= qy_next;
        qx2_reg <= qx2_next;
        qy2_reg <= qy2_next;
    end

    assign out_valid = out_valid_reg;
    assign hit = out_hit_reg;
    assign out_of_bounds = out_oob_reg;
    assign entry_count = out_count_reg;
    assign status = out_status_reg;

endmodule
